@@ hdl/ltok_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line tokenizer package
// Shared types and constants for the line tokenizer front end, queue and
// back end.
// ----------------------------------------------------------------------------
package ltok_pkg;

	localparam int TEXT_CAPACITY_DEF = 512;
	localparam int QUEUE_DEPTH       = 4;

	localparam logic [2:0] KIND_NAME = 3'd0;
	localparam logic [2:0] KIND_INT  = 3'd1;
	localparam logic [2:0] KIND_STR  = 3'd2;
	localparam logic [2:0] KIND_EOL  = 3'd3;
	localparam logic [2:0] KIND_CHAR = 3'd4;

	localparam logic [7:0] CH_MINUS = 8'h2D;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_NAME,
		MODE_INT,
		MODE_STR
	} scan_mode_t;

	typedef enum logic [3:0] {
		CLS_BLANK,
		CLS_LETTER,
		CLS_DIGIT,
		CLS_UNDER,
		CLS_AT,
		CLS_SIGN,
		CLS_QUOTE,
		CLS_NUL,
		CLS_OTHER
	} char_class_t;

	typedef struct packed {
		char_class_t cls;
		logic [7:0]  ch;
	} char_entry_t;

	typedef struct packed {
		logic [2:0]  token_kind;
		logic [7:0]  text_byte;
		logic        text_valid;
		logic        token_done;
		logic [31:0] int_value;
		logic [8:0]  text_length;
		logic        truncated;
		logic        last;
	} token_beat_t;

endpackage

@@ hdl/ltok_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line tokenizer front end
// Accepts input characters, classifies them and registers the classified
// character toward the queue.
// ----------------------------------------------------------------------------
module ltok_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_char,
	output logic                 q_valid,
	input  logic                 q_ready,
	output ltok_pkg::char_entry_t q_data
);
	import ltok_pkg::*;

	logic        valid_s1;
	char_entry_t ent_s1;
	char_class_t cls;

	always_comb begin
		if (in_char == 8'h20 || in_char == 8'h09 || in_char == 8'h0D || in_char == 8'h0A) begin
			cls = CLS_BLANK;
		end else if ((in_char >= 8'h41 && in_char <= 8'h5A) ||
				(in_char >= 8'h61 && in_char <= 8'h7A)) begin
			cls = CLS_LETTER;
		end else if (in_char >= 8'h30 && in_char <= 8'h39) begin
			cls = CLS_DIGIT;
		end else if (in_char == 8'h5F) begin
			cls = CLS_UNDER;
		end else if (in_char == 8'h40) begin
			cls = CLS_AT;
		end else if (in_char == 8'h2D || in_char == 8'h2B) begin
			cls = CLS_SIGN;
		end else if (in_char == 8'h22) begin
			cls = CLS_QUOTE;
		end else if (in_char == 8'h00) begin
			cls = CLS_NUL;
		end else begin
			cls = CLS_OTHER;
		end
	end

	assign in_ready = !valid_s1 || q_ready;
	assign q_valid  = valid_s1;
	assign q_data   = ent_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ent_s1.cls <= cls;
			ent_s1.ch  <= in_char;
		end
	end

endmodule

@@ hdl/ltok_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line tokenizer queue
// Short first-in first-out buffer of classified characters between the
// front end and the back end.
// ----------------------------------------------------------------------------
module ltok_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  ltok_pkg::char_entry_t push_data,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output ltok_pkg::char_entry_t pop_data
);
	import ltok_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	char_entry_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [PTR_W:0]         count_q;
	logic                   do_push;
	logic                   do_pop;

	assign push_ready = count_q != (PTR_W+1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ hdl/ltok_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line tokenizer back end
// Holds the scan state, turns each classified character into zero, one or
// two result beats and presents them through an output register.
// ----------------------------------------------------------------------------
module ltok_back #(
	parameter int TextCapacity = ltok_pkg::TEXT_CAPACITY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  ltok_pkg::char_entry_t q_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ltok_pkg::token_beat_t out_beat
);
	import ltok_pkg::*;

	localparam int CNT_W = $clog2(TextCapacity);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TextCapacity - 1);

	scan_mode_t     mode_q, mode_d;
	logic [31:0]    acc_q, acc_d;
	logic           neg_q, neg_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic           cut_q, cut_d;

	token_beat_t    out_q, pend_q;
	logic           out_valid_q, pend_valid_q;

	char_class_t    cls;
	logic [7:0]     ch;
	logic           is_dig, is_quote, is_nul;
	logic           cont, fin, run_idle, idle_has, two, any;
	logic           kept, cut_app, load_ok, pop;
	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W+8:0] len_cur_ext, len_inc_ext;
	logic [35:0]    acc_wide;
	logic [31:0]    limit, acc_sat, fin_val;
	logic [2:0]     mode_kind;
	token_beat_t    app_res, fin_res, idle_res, first_res, second_res;

	assign cls      = q_data.cls;
	assign ch       = q_data.ch;
	assign is_dig   = cls == CLS_DIGIT;
	assign is_quote = cls == CLS_QUOTE;
	assign is_nul   = cls == CLS_NUL;

	assign kept        = cnt_q < CNT_MAX;
	assign cnt_inc     = kept ? cnt_q + 1'b1 : cnt_q;
	assign cut_app     = cut_q || !kept;
	assign len_cur_ext = {9'd0, cnt_q};
	assign len_inc_ext = {9'd0, cnt_inc};

	assign acc_wide = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {32'd0, ch[3:0]};
	assign limit    = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
	assign acc_sat  = (acc_wide > {4'd0, limit}) ? limit : acc_wide[31:0];
	assign fin_val  = (mode_q != MODE_INT) ? 32'd0 : (neg_q ? (32'd0 - acc_q) : acc_q);

	always_comb begin
		cont = 1'b0;
		fin  = 1'b0;
		unique case (mode_q)
			MODE_NAME: begin
				cont = cls inside {CLS_LETTER, CLS_DIGIT, CLS_UNDER};
				fin  = !cont;
			end
			MODE_INT: begin
				cont = is_dig;
				fin  = !is_dig;
			end
			MODE_STR: begin
				cont = !(is_quote || is_nul);
				fin  = is_quote || is_nul;
			end
			MODE_IDLE: begin
				cont = 1'b0;
				fin  = 1'b0;
			end
		endcase
	end

	assign run_idle = (mode_q == MODE_IDLE) || (fin && !(mode_q == MODE_STR && is_quote));
	assign idle_has = !(cls == CLS_BLANK || is_quote);
	assign two      = fin && run_idle && idle_has;
	assign any      = cont || fin || (run_idle && idle_has);

	always_comb begin
		unique case (mode_q)
			MODE_NAME: mode_kind = KIND_NAME;
			MODE_INT:  mode_kind = KIND_INT;
			default:   mode_kind = KIND_STR;
		endcase
	end

	always_comb begin
		app_res             = '0;
		app_res.token_kind  = mode_kind;
		app_res.text_byte   = kept ? ch : 8'd0;
		app_res.text_valid  = kept;
		app_res.text_length = len_inc_ext[8:0];
		app_res.truncated   = cut_app;

		fin_res             = '0;
		fin_res.token_kind  = mode_kind;
		fin_res.token_done  = 1'b1;
		fin_res.int_value   = fin_val;
		fin_res.text_length = len_cur_ext[8:0];
		fin_res.truncated   = cut_q;

		idle_res = '0;
		case (cls)
			CLS_LETTER, CLS_UNDER, CLS_AT: begin
				idle_res.token_kind  = KIND_NAME;
				idle_res.text_byte   = ch;
				idle_res.text_valid  = 1'b1;
				idle_res.text_length = 9'd1;
			end
			CLS_DIGIT, CLS_SIGN: begin
				idle_res.token_kind  = KIND_INT;
				idle_res.text_byte   = ch;
				idle_res.text_valid  = 1'b1;
				idle_res.text_length = 9'd1;
			end
			CLS_NUL: begin
				idle_res.token_kind = KIND_EOL;
				idle_res.token_done = 1'b1;
			end
			CLS_OTHER: begin
				idle_res.token_kind  = KIND_CHAR;
				idle_res.text_byte   = ch;
				idle_res.text_valid  = 1'b1;
				idle_res.token_done  = 1'b1;
				idle_res.text_length = 9'd1;
			end
			default: begin
				idle_res = '0;
			end
		endcase

		if (cont) begin
			first_res = app_res;
		end else if (fin) begin
			first_res = fin_res;
		end else begin
			first_res = idle_res;
		end
		first_res.last  = !two;
		second_res      = idle_res;
		second_res.last = 1'b1;
	end

	always_comb begin
		mode_d = mode_q;
		acc_d  = acc_q;
		neg_d  = neg_q;
		cnt_d  = cnt_q;
		cut_d  = cut_q;
		if (cont) begin
			cnt_d = cnt_inc;
			cut_d = cut_app;
			if (mode_q == MODE_INT && kept) begin
				acc_d = acc_sat;
			end
		end else begin
			if (fin) begin
				mode_d = MODE_IDLE;
			end
			if (run_idle && cls != CLS_BLANK) begin
				acc_d = 32'd0;
				neg_d = 1'b0;
				cnt_d = '0;
				cut_d = 1'b0;
				case (cls)
					CLS_LETTER, CLS_UNDER, CLS_AT: begin
						mode_d = MODE_NAME;
						cnt_d  = CNT_W'(1);
					end
					CLS_DIGIT: begin
						mode_d = MODE_INT;
						acc_d  = {28'd0, ch[3:0]};
						cnt_d  = CNT_W'(1);
					end
					CLS_SIGN: begin
						mode_d = MODE_INT;
						neg_d  = ch == CH_MINUS;
						cnt_d  = CNT_W'(1);
					end
					CLS_QUOTE: begin
						mode_d = MODE_STR;
					end
					default: begin
						mode_d = MODE_IDLE;
					end
				endcase
			end
		end
	end

	assign load_ok   = !out_valid_q || out_ready;
	assign pop       = q_valid && load_ok && !pend_valid_q;
	assign q_ready   = load_ok && !pend_valid_q;
	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			acc_q        <= 32'd0;
			neg_q        <= 1'b0;
			cnt_q        <= '0;
			cut_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q <= mode_d;
				acc_q  <= acc_d;
				neg_q  <= neg_d;
				cnt_q  <= cnt_d;
				cut_q  <= cut_d;
			end
			if (load_ok) begin
				if (pend_valid_q) begin
					out_valid_q  <= 1'b1;
					pend_valid_q <= 1'b0;
				end else if (pop && any) begin
					out_valid_q  <= 1'b1;
					pend_valid_q <= two;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (pop && any) begin
				out_q  <= first_res;
				pend_q <= second_res;
			end
		end
	end

endmodule

@@ hdl/line_tokenizer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line tokenizer core
// Splits a character stream into name, integer, string, single character
// and end of line tokens, reporting token text one byte per result beat.
// ----------------------------------------------------------------------------
// Path: an input beat goes through the front-end register, the queue and the
// back-end output register. Throughput: one input beat per cycle while the
// output accepts; an input that ends a token and starts another gives two
// result beats; the single output register sends them in turn, holding the queue.
// Reset: arst_n clears the scan state, the queue and all valid flags at once.
module line_tokenizer_core #(
	parameter int TextCapacity = ltok_pkg::TEXT_CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_char[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // token_kind[2:0], text_byte[10:3], text_valid[11],
	                               // token_done[12], int_value[44:13],
	                               // text_length[53:45], truncated[54], zero[55]
	output logic        m_tlast
);
	import ltok_pkg::*;

	logic        f_valid, f_ready, b_valid, b_ready;
	char_entry_t f_data, b_data;
	token_beat_t beat;

	ltok_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_char  (s_tdata),
		.q_valid  (f_valid),
		.q_ready  (f_ready),
		.q_data   (f_data)
	);

	ltok_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_data),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_data)
	);

	ltok_back #(
		.TextCapacity (TextCapacity)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (b_valid),
		.q_ready   (b_ready),
		.q_data    (b_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_beat  (beat)
	);

	assign m_tdata = {1'b0, beat.truncated, beat.text_length, beat.int_value,
		beat.token_done, beat.text_valid, beat.text_byte, beat.token_kind};
	assign m_tlast = beat.last;

endmodule

@@ dv/tb_line_tokenizer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line tokenizer core testbench
// Feeds character beats into the tokenizer and checks every result beat
// against a predictor of the scanner that runs beside it. A short directed
// line comes first. Then come tokens long enough to fill the text store, and
// then random token streams. The random streams run under four idle
// patterns on the input and output sides.
// ----------------------------------------------------------------------------
module tb_line_tokenizer_core;
	import ltok_pkg::*;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	localparam int PHASE_ITEMS  = 140;
	localparam int DRAIN_CYCLES = 8;

	class token_scoreboard;
		token_beat_t expected_beats[$];
		scan_mode_t  mode;
		logic [31:0] magnitude;
		logic        negative;
		int          text_count;
		logic        cut;
		int          errors;

		function new();
			mode       = MODE_IDLE;
			magnitude  = '0;
			negative   = 1'b0;
			text_count = 0;
			cut        = 1'b0;
			errors     = 0;
		endfunction

		static function bit is_letter(logic [7:0] ch);
			return (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z");
		endfunction

		static function bit is_digit(logic [7:0] ch);
			return ch >= CH_ZERO && ch <= CH_NINE;
		endfunction

		static function bit is_blank(logic [7:0] ch);
			return ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_LF;
		endfunction

		function logic [2:0] mode_kind();
			case (mode)
				MODE_NAME: return KIND_NAME;
				MODE_INT:  return KIND_INT;
				default:   return KIND_STR;
			endcase
		endfunction

		function void push_beat(logic [2:0] kind, logic [7:0] ch, logic valid, logic done,
		                        logic [31:0] value, int len, logic cut_now);
			token_beat_t b;
			b.token_kind  = kind;
			b.text_byte   = ch;
			b.text_valid  = valid;
			b.token_done  = done;
			b.int_value   = value;
			b.text_length = len[8:0];
			b.truncated   = cut_now;
			b.last        = 1'b0;
			expected_beats.push_back(b);
		endfunction

		function void start_token(scan_mode_t m);
			mode       = m;
			magnitude  = '0;
			negative   = 1'b0;
			text_count = 0;
			cut        = 1'b0;
		endfunction

		function void append_char(logic [7:0] ch);
			logic [31:0] limit;
			logic [63:0] sum;
			logic        kept;
			kept = 1'b0;
			if (text_count < TEXT_CAPACITY_DEF - 1) begin
				text_count++;
				kept = 1'b1;
				if (mode == MODE_INT && is_digit(ch)) begin
					limit     = negative ? 32'h8000_0000 : 32'h7FFF_FFFF;
					sum       = 64'(magnitude) * 64'd10 + 64'(ch - CH_ZERO);
					magnitude = (sum > 64'(limit)) ? limit : sum[31:0];
				end
			end else begin
				cut = 1'b1;
			end
			push_beat(mode_kind(), kept ? ch : 8'd0, kept, 1'b0, 32'd0, text_count, cut);
		endfunction

		function void finish_token();
			logic [31:0] value;
			value = '0;
			if (mode == MODE_INT)
				value = negative ? (32'd0 - magnitude) : magnitude;
			push_beat(mode_kind(), 8'd0, 1'b0, 1'b1, value, text_count, cut);
			mode = MODE_IDLE;
		endfunction

		function void between_tokens(logic [7:0] ch);
			if (is_blank(ch))
				return;
			if (is_letter(ch) || ch == CH_UNDER || ch == CH_AT) begin
				start_token(MODE_NAME);
				append_char(ch);
			end else if (is_digit(ch) || ch == CH_MINUS || ch == CH_PLUS) begin
				start_token(MODE_INT);
				negative = (ch == CH_MINUS);
				append_char(ch);
			end else if (ch == CH_QUOTE) begin
				start_token(MODE_STR);
			end else if (ch == CH_NUL) begin
				start_token(MODE_IDLE);
				push_beat(KIND_EOL, 8'd0, 1'b0, 1'b1, 32'd0, 0, 1'b0);
			end else begin
				start_token(MODE_IDLE);
				push_beat(KIND_CHAR, ch, 1'b1, 1'b1, 32'd0, 1, 1'b0);
			end
		endfunction

		function void note_char(logic [7:0] ch);
			int          count_at_entry;
			token_beat_t tail;
			count_at_entry = expected_beats.size();
			case (mode)
				MODE_NAME: begin
					if (is_letter(ch) || is_digit(ch) || ch == CH_UNDER) begin
						append_char(ch);
					end else begin
						finish_token();
						between_tokens(ch);
					end
				end
				MODE_INT: begin
					if (is_digit(ch)) begin
						append_char(ch);
					end else begin
						finish_token();
						between_tokens(ch);
					end
				end
				MODE_STR: begin
					if (ch == CH_QUOTE) begin
						finish_token();
					end else if (ch == CH_NUL) begin
						finish_token();
						between_tokens(ch);
					end else begin
						append_char(ch);
					end
				end
				default: between_tokens(ch);
			endcase
			if (expected_beats.size() > count_at_entry) begin
				tail = expected_beats.pop_back();
				tail.last = 1'b1;
				expected_beats.push_back(tail);
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_beat(logic [55:0] data, logic tlast);
			token_beat_t want;
			if (expected_beats.size() == 0) begin
				errors++;
				$display("%0t: result beat with none expected, expected none, actual %h",
				         $time, data);
				return;
			end
			want = expected_beats.pop_front();
			compare_field("token_kind", 32'(want.token_kind), 32'(data[2:0]));
			compare_field("text_byte", 32'(want.text_byte), 32'(data[10:3]));
			compare_field("text_valid", 32'(want.text_valid), 32'(data[11]));
			compare_field("token_done", 32'(want.token_done), 32'(data[12]));
			compare_field("int_value", want.int_value, data[44:13]);
			compare_field("text_length", 32'(want.text_length), 32'(data[53:45]));
			compare_field("truncated", 32'(want.truncated), 32'(data[54]));
			compare_field("pad", 32'd0, 32'(data[55]));
			compare_field("last", 32'(want.last), 32'(tlast));
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        m_tlast;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int items_sent = 0;

	token_scoreboard sb;

	line_tokenizer_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_char(s_tdata);
			if (m_tvalid && m_tready)
				sb.check_beat(m_tdata, m_tlast);
		end
	end

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_name_start();
		int pick;
		pick = $urandom_range(0, 53);
		if (pick < 26)
			return "A" + 8'(pick);
		if (pick < 52)
			return "a" + 8'(pick - 26);
		return (pick == 52) ? CH_UNDER : CH_AT;
	endfunction

	function automatic logic [7:0] rand_name_cont();
		int pick;
		pick = $urandom_range(0, 62);
		if (pick < 26)
			return "A" + 8'(pick);
		if (pick < 52)
			return "a" + 8'(pick - 26);
		if (pick < 62)
			return CH_ZERO + 8'(pick - 52);
		return CH_UNDER;
	endfunction

	function automatic logic [7:0] rand_blank();
		case ($urandom_range(0, 3))
			0:       return CH_SPACE;
			1:       return CH_TAB;
			2:       return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	function automatic logic [7:0] rand_string_char();
		logic [7:0] ch;
		ch = 8'($urandom_range(1, 255));
		while (ch == CH_QUOTE)
			ch = 8'($urandom_range(1, 255));
		return ch;
	endfunction

	function automatic logic [7:0] rand_other();
		logic [7:0] ch;
		ch = CH_QUOTE;
		while (ch == CH_QUOTE || ch == CH_UNDER || ch == CH_AT || ch == CH_MINUS ||
		       ch == CH_PLUS || token_scoreboard::is_letter(ch) ||
		       token_scoreboard::is_digit(ch) || token_scoreboard::is_blank(ch))
			ch = 8'($urandom_range(1, 255));
		return ch;
	endfunction

	task automatic send_char(logic [7:0] ch);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic send_random_token();
		int sel;
		int n;
		case ($urandom_range(0, 11))
			0, 1, 2: begin
				send_char(rand_name_start());
				n = $urandom_range(0, 8);
				repeat (n) send_char(rand_name_cont());
			end
			3, 4, 5: begin
				sel = $urandom_range(0, 2);
				if (sel == 1)
					send_char(CH_MINUS);
				else if (sel == 2)
					send_char(CH_PLUS);
				n = $urandom_range((sel == 0) ? 1 : 0, 12);
				repeat (n) send_char(rand_digit());
			end
			6: begin
				send_char(CH_QUOTE);
				n = $urandom_range(0, 8);
				repeat (n) send_char(rand_string_char());
				send_char(($urandom_range(0, 3) == 0) ? CH_NUL : CH_QUOTE);
			end
			7: send_char(rand_other());
			8: begin
				n = $urandom_range(1, 3);
				repeat (n) send_char(rand_blank());
			end
			9: send_char(CH_NUL);
			default: send_char(8'($urandom_range(0, 255)));
		endcase
		if ($urandom_range(0, 9) < 4)
			send_char(rand_blank());
	endtask

	task automatic send_long_tokens();
		int n;
		n = TEXT_CAPACITY_DEF + 3;
		send_char("n");
		repeat (n) send_char(rand_name_cont());
		send_char(CH_SPACE);
		send_char(CH_MINUS);
		repeat (n) send_char(rand_digit());
		send_char(CH_SPACE);
		send_char(CH_QUOTE);
		repeat (n) send_char(rand_string_char());
		send_char(CH_QUOTE);
	endtask

	task automatic run_random(int idle_pct, int stall_pct);
		int goal;
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		goal = items_sent + PHASE_ITEMS;
		while (items_sent < goal)
			send_random_token();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_text("@a_9\t-,+07\r\"\"\"");
		send_char(8'hFF);
		send_text("\"z");
		send_char(8'h80);
		send_text("\n\"q");
		send_char(CH_NUL);
		send_char(CH_NUL);
		send_text("5");
		send_char(CH_NUL);
		send_long_tokens();

		run_random(0, 0);
		run_random(84, 0);
		run_random(0, 84);
		run_random(13, 13);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

@@ line_tokenizer_core.f @@
hdl/ltok_pkg.sv
hdl/ltok_front.sv
hdl/ltok_queue.sv
hdl/ltok_back.sv
hdl/line_tokenizer_core.sv
dv/tb_line_tokenizer_core.sv
